// File: design/odc_pkg.sv
package odc_pkg;

  // Command codes of an input beat
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Motor drive codes
  localparam logic [1:0] DRV_STOP = 2'd0;
  localparam logic [1:0] DRV_FWD  = 2'd1;
  localparam logic [1:0] DRV_BACK = 2'd2;

  // LED colors
  localparam logic LED_GREEN = 1'b0;
  localparam logic LED_RED   = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD = 3'd5;

  // Register reset values
  localparam logic [15:0] NEAR_RST = 16'd0;
  localparam logic [15:0] FAR_RST  = 16'd0;
  localparam logic [15:0] STOP_RST = 16'd500;
  localparam logic [15:0] BACK_RST = 16'd3000;
  localparam logic [15:0] TURN_RST = 16'd1000;
  localparam logic [15:0] HOLD_RST = 16'd4000;

  typedef struct packed {
    logic        command;
    logic [15:0] distance;
    logic        random_bit;
  } in_t;

  typedef struct packed {
    logic [1:0] left_drive;
    logic [1:0] right_drive;
    logic       warning_led;
  } out_t;

  typedef struct packed {
    logic [15:0] near_threshold;
    logic [15:0] far_threshold;
    logic [15:0] stop_ticks;
    logic [15:0] back_ticks;
    logic [15:0] turn_ticks;
    logic [15:0] hold_ticks;
  } cfg_t;

endpackage

// File: design/odc_ctrl.sv
module odc_ctrl #(
  parameter int unsigned AVERAGE_COUNT = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  odc_pkg::in_t  item_i,
  input  odc_pkg::cfg_t cfg_i,
  output odc_pkg::out_t result_o
);

  localparam int unsigned CLOG_N  = $clog2(AVERAGE_COUNT);
  localparam int unsigned CNT_W   = (CLOG_N > 0) ? CLOG_N : 1;
  localparam int unsigned SUM_W   = 16 + CLOG_N;
  // Exact divide by reciprocal: floor(x * ceil(2^K / N) / 2^K) for x < 2^SUM_W
  localparam int unsigned K       = SUM_W + CLOG_N;
  localparam int unsigned RECIP_W = K + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << K) + 64'(AVERAGE_COUNT) - 64'd1) / 64'(AVERAGE_COUNT);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam logic [CNT_W-1:0]   LAST  = CNT_W'(AVERAGE_COUNT - 1);

  typedef enum logic [1:0] {
    PH_SAMPLING,
    PH_STOPPING,
    PH_BACKING,
    PH_TURNING
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [15:0]        ptim_q, ptim_d;
  logic [15:0]        hold_q, hold_d;
  logic               held_q, held_d;
  logic [1:0]         left_q, left_d;
  logic [1:0]         right_q, right_d;
  logic               led_q, led_d;

  logic [SUM_W-1:0]   sum_add;
  logic [PROD_W-1:0]  prod;
  logic [15:0]        avg;
  logic [15:0]        ptim_dec;
  logic               dir;

  // Running sum and its average
  assign sum_add = sum_q + SUM_W'(item_i.distance);
  assign prod    = PROD_W'(sum_add) * PROD_W'(RECIP);
  assign avg     = prod[K +: 16];

  assign ptim_dec = (ptim_q != 16'd0) ? ptim_q - 16'd1 : ptim_q;
  assign dir      = (hold_q == 16'd0) ? item_i.random_bit : held_q;

  // Next state for one accepted beat
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    sum_d   = sum_q;
    ptim_d  = ptim_q;
    hold_d  = hold_q;
    held_d  = held_q;
    left_d  = left_q;
    right_d = right_q;
    led_d   = led_q;
    if (accept_i) begin
      if (item_i.command == odc_pkg::CMD_SAMPLE) begin
        if (phase_q == PH_SAMPLING) begin
          if (count_q == LAST) begin
            count_d = '0;
            sum_d   = '0;
            if (avg < cfg_i.near_threshold) begin
              led_d   = odc_pkg::LED_RED;
              left_d  = odc_pkg::DRV_STOP;
              right_d = odc_pkg::DRV_STOP;
              phase_d = PH_STOPPING;
              ptim_d  = cfg_i.stop_ticks;
            end else if (avg < cfg_i.far_threshold) begin
              led_d = odc_pkg::LED_RED;
              if (hold_q == 16'd0) begin
                held_d = item_i.random_bit;
                hold_d = cfg_i.hold_ticks;
              end
              left_d  = dir ? odc_pkg::DRV_BACK : odc_pkg::DRV_FWD;
              right_d = dir ? odc_pkg::DRV_FWD : odc_pkg::DRV_BACK;
              phase_d = PH_TURNING;
              ptim_d  = cfg_i.turn_ticks;
            end else begin
              led_d   = odc_pkg::LED_GREEN;
              left_d  = odc_pkg::DRV_FWD;
              right_d = odc_pkg::DRV_FWD;
            end
          end else begin
            count_d = count_q + CNT_W'(1);
            sum_d   = sum_add;
          end
        end
      end else begin
        if (hold_q != 16'd0) begin
          hold_d = hold_q - 16'd1;
        end
        if (phase_q != PH_SAMPLING) begin
          ptim_d = ptim_dec;
          if (ptim_dec == 16'd0) begin
            unique case (phase_q)
              PH_STOPPING: begin
                left_d  = odc_pkg::DRV_BACK;
                right_d = odc_pkg::DRV_BACK;
                phase_d = PH_BACKING;
                ptim_d  = cfg_i.back_ticks;
              end
              PH_BACKING: begin
                left_d  = item_i.random_bit ? odc_pkg::DRV_FWD : odc_pkg::DRV_BACK;
                right_d = item_i.random_bit ? odc_pkg::DRV_BACK : odc_pkg::DRV_FWD;
                phase_d = PH_TURNING;
                ptim_d  = cfg_i.turn_ticks;
              end
              default: begin
                phase_d = PH_SAMPLING;
                count_d = '0;
                sum_d   = '0;
                ptim_d  = 16'd0;
              end
            endcase
          end
        end
      end
    end
  end

  // Hold controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SAMPLING;
      count_q <= '0;
      sum_q   <= '0;
      ptim_q  <= 16'd0;
      hold_q  <= 16'd0;
      held_q  <= 1'b0;
      left_q  <= odc_pkg::DRV_FWD;
      right_q <= odc_pkg::DRV_FWD;
      led_q   <= odc_pkg::LED_GREEN;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      ptim_q  <= ptim_d;
      hold_q  <= hold_d;
      held_q  <= held_d;
      left_q  <= left_d;
      right_q <= right_d;
      led_q   <= led_d;
    end
  end

  assign result_o.left_drive  = left_d;
  assign result_o.right_drive = right_d;
  assign result_o.warning_led = led_d;

endmodule

// File: design/obstacle_avoid_drive_controller_core.sv
// A result beat is registered in the result register, or in the skid entry if one waits.
// One input beat per cycle while in_stall_o is low; every beat yields exactly one result beat.
// A two-entry output buffer (result register plus skid) keeps input open while
// one result waits; in_stall_o rises only when both entries are full.
// Reset (rst_ni low, asynchronous): sampling phase, empty sum, timers zero,
// both motors forward, LED green, registers at their default values.
module obstacle_avoid_drive_controller_core #(
  parameter int unsigned AVERAGE_COUNT = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  odc_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output odc_pkg::out_t                    out_data_o,
  input  logic                             cfg_we_i,
  input  logic [odc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [15:0]                      cfg_data_i
);

  odc_pkg::cfg_t cfg_q;
  odc_pkg::out_t result;
  odc_pkg::out_t main_q;
  odc_pkg::out_t skid_q;
  logic          main_v_q;
  logic          skid_v_q;
  logic          push;
  logic          pop;

  assign push = in_valid_i && !skid_v_q;
  assign pop  = main_v_q && !out_stall_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_threshold <= odc_pkg::NEAR_RST;
      cfg_q.far_threshold  <= odc_pkg::FAR_RST;
      cfg_q.stop_ticks     <= odc_pkg::STOP_RST;
      cfg_q.back_ticks     <= odc_pkg::BACK_RST;
      cfg_q.turn_ticks     <= odc_pkg::TURN_RST;
      cfg_q.hold_ticks     <= odc_pkg::HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        odc_pkg::REG_NEAR: cfg_q.near_threshold <= cfg_data_i;
        odc_pkg::REG_FAR:  cfg_q.far_threshold  <= cfg_data_i;
        odc_pkg::REG_STOP: cfg_q.stop_ticks     <= cfg_data_i;
        odc_pkg::REG_BACK: cfg_q.back_ticks     <= cfg_data_i;
        odc_pkg::REG_TURN: cfg_q.turn_ticks     <= cfg_data_i;
        odc_pkg::REG_HOLD: cfg_q.hold_ticks     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  odc_ctrl #(
    .AVERAGE_COUNT(AVERAGE_COUNT)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(push),
    .item_i  (in_data_i),
    .cfg_i   (cfg_q),
    .result_o(result)
  );

  // Output buffer: valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (skid_v_q) begin
        if (pop) begin
          skid_v_q <= 1'b0;
        end
      end else if (push) begin
        if (main_v_q && !pop) begin
          skid_v_q <= 1'b1;
        end else begin
          main_v_q <= 1'b1;
        end
      end else if (pop) begin
        main_v_q <= 1'b0;
      end
    end
  end

  // Output buffer: payload, advance skid into result register on a taken beat
  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push) begin
      if (main_v_q && !pop) begin
        skid_q <= result;
      end else begin
        main_q <= result;
      end
    end
  end

  assign in_stall_o  = skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

  // Skid entry is never filled while the result register is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_v_q |-> main_v_q)
    else $error("skid holds a beat while result register is empty");

  // An accepted beat always leaves a result beat on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted beat produced no result");

  // Offered drive codes are legal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.left_drive != 2'd3 && out_data_o.right_drive != 2'd3))
    else $error("illegal drive code on output");

endmodule
